// ----- rtl/core/tdma_slot_state_scheduler_assert.svh -----
// ----------------------------------------------------------------------------
// TDMA slot scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TDMA_SLOT_STATE_SCHEDULER_ASSERT_SVH
`define TDMA_SLOT_STATE_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define TSS_ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define TSS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/core/tss_pkg.sv -----
// ----------------------------------------------------------------------------
// TDMA slot scheduler package
// Widths, register indexes, radio state codes and payload structs.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int ADDR_WIDTH     = 16;
  localparam int SLOT_WIDTH     = 8;
  localparam int DIST_WIDTH     = SLOT_WIDTH + 1;
  localparam int CFG_DATA_WIDTH = (ADDR_WIDTH > SLOT_WIDTH) ? ADDR_WIDTH : SLOT_WIDTH;
  localparam int CFG_IDX_WIDTH  = 2;

  localparam logic [SLOT_WIDTH-1:0] SLOT_COUNT_RESET = SLOT_WIDTH'(16);

  // Configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SLOT_COUNT   = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_NODE_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SINK_MODE    = 2'd2;

  // Radio state codes
  localparam logic [1:0] ST_SLEEP        = 2'd0;
  localparam logic [1:0] ST_RECEIVE      = 2'd1;
  localparam logic [1:0] ST_SEND         = 2'd2;
  localparam logic [1:0] ST_SEND_RECEIVE = 2'd3;

  typedef struct packed {
    logic                  has_message;
    logic                  is_broadcast;
    logic [ADDR_WIDTH-1:0] dest_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            slot_state;
    logic [SLOT_WIDTH-1:0] slot_index;
    logic                  drop_message;
    logic [DIST_WIDTH-1:0] wake_distance;
  } out_item_t;

endpackage

// ----- rtl/core/tdma_slot_state_scheduler.sv -----
// ----------------------------------------------------------------------------
// TDMA slot state scheduler
// Per slot boundary: radio state, drop flag and wake distance, then advance.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------
//  in       | input     | in_valid/in_stall  | in_item_t  (slot boundary)
//  out      | output    | out_valid/out_stall| out_item_t (slot decision)
//  cfg      | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// In a transaction, the accept loads both bit-serial remainder units, ADDR_WIDTH
// steps form the own and destination slots, and the finish state forms the
// decision and advances. in_stall is high from accept until the result is in
// the output register. A stalled result holds the next transaction in the
// finish state. rst (synchronous, active high) sets slot_count to 16, idles the
// sequencer and clears the other config registers, step_cnt, cur_slot and out_valid.
// ----------------------------------------------------------------------------
module tdma_slot_state_scheduler
  import tss_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

  `include "tdma_slot_state_scheduler_assert.svh"

  localparam int CNT_WIDTH = $clog2(ADDR_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RUN    = 3'b010,
    S_FINISH = 3'b100
  } fsm_t;

  fsm_t fsm, fsm_next;

  // Configuration registers
  logic [SLOT_WIDTH-1:0] slot_count;
  logic [ADDR_WIDTH-1:0] node_address;
  logic                  sink_mode;

  // Slot counter and held transaction
  logic [SLOT_WIDTH-1:0] cur_slot;
  logic [CNT_WIDTH-1:0]  step_cnt;
  in_item_t              item;

  logic                  in_accept;
  logic                  out_load;
  logic [SLOT_WIDTH-1:0] slots_eff;
  logic [SLOT_WIDTH-1:0] own_slot;
  logic [SLOT_WIDTH-1:0] dest_slot;

  assign cfg_ready = 1'b1;
  assign in_stall  = (fsm != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (fsm == S_FINISH) && (!out_valid || !out_stall);

  // A zero slot count acts as one
  assign slots_eff = (slot_count == '0) ? SLOT_WIDTH'(1) : slot_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count   <= SLOT_COUNT_RESET;
      node_address <= '0;
      sink_mode    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLOT_COUNT:   slot_count   <= cfg_data[SLOT_WIDTH-1:0];
        CFG_NODE_ADDRESS: node_address <= cfg_data[ADDR_WIDTH-1:0];
        CFG_SINK_MODE:    sink_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Own listening slot and destination slot, one bit per cycle each
  tss_rem_serial #(
    .DIVIDEND_WIDTH(ADDR_WIDTH),
    .DIVISOR_WIDTH (SLOT_WIDTH)
  ) u_rem_own (
    .clk      (clk),
    .load     (in_accept),
    .step     (fsm == S_RUN),
    .dividend (node_address),
    .divisor  (slots_eff),
    .remainder(own_slot)
  );

  tss_rem_serial #(
    .DIVIDEND_WIDTH(ADDR_WIDTH),
    .DIVISOR_WIDTH (SLOT_WIDTH)
  ) u_rem_dest (
    .clk      (clk),
    .load     (in_accept),
    .step     (fsm == S_RUN),
    .dividend (in_data.dest_address),
    .divisor  (slots_eff),
    .remainder(dest_slot)
  );

  // Sequencer
  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      S_IDLE:   if (in_accept) fsm_next = S_RUN;
      S_RUN:    if (step_cnt == CNT_WIDTH'(ADDR_WIDTH - 1)) fsm_next = S_FINISH;
      S_FINISH: if (out_load) fsm_next = S_IDLE;
      default:  fsm_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm      <= S_IDLE;
      step_cnt <= '0;
    end else begin
      fsm <= fsm_next;
      if (in_accept) begin
        step_cnt <= '0;
      end else if (fsm == S_RUN) begin
        step_cnt <= step_cnt + CNT_WIDTH'(1);
      end
    end
  end

  // Hold the transaction fields for the decision cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item <= in_data;
    end
  end

  // Decision
  logic                  unicast;
  logic                  drop;
  logic                  pending;
  logic                  in_common;
  logic                  dest_awake;
  logic [1:0]            state_sel;
  logic [SLOT_WIDTH+1:0] dist_wide;
  logic [SLOT_WIDTH-1:0] cur_slot_next;

  always_comb begin
    unicast    = item.has_message && !item.is_broadcast;
    drop       = unicast && (dest_slot == own_slot);
    pending    = item.has_message && !drop;
    in_common  = (cur_slot == slots_eff);
    dest_awake = (dest_slot == cur_slot) ||
                 (sink_mode && (item.dest_address == '0) && !in_common);

    priority if (cur_slot == own_slot) begin
      state_sel = ST_RECEIVE;
    end else if (pending && item.is_broadcast && in_common) begin
      state_sel = ST_SEND_RECEIVE;
    end else if (pending && !item.is_broadcast && dest_awake) begin
      state_sel = ST_SEND;
    end else if (in_common) begin
      state_sel = ST_RECEIVE;
    end else if (sink_mode && (node_address == '0)) begin
      state_sel = ST_RECEIVE;
    end else begin
      state_sel = ST_SLEEP;
    end

    // Advances until the destination slot, zero unless a unicast is kept; a counter
    // past the common slot counts as if the next slot were zero
    priority if (!(unicast && !drop)) begin
      dist_wide = '0;
    end else if (cur_slot > slots_eff) begin
      dist_wide = {2'b00, dest_slot} + (SLOT_WIDTH+2)'(1);
    end else if (dest_slot > cur_slot) begin
      dist_wide = {2'b00, dest_slot} - {2'b00, cur_slot};
    end else begin
      dist_wide = {2'b00, dest_slot} + {2'b00, slots_eff} + (SLOT_WIDTH+2)'(1)
                  - {2'b00, cur_slot};
    end

    // Wrap after the common slot
    if (cur_slot >= slots_eff) begin
      cur_slot_next = '0;
    end else begin
      cur_slot_next = cur_slot + SLOT_WIDTH'(1);
    end
  end

  // Output register and slot counter advance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_slot  <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        cur_slot  <= cur_slot_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.slot_state    <= state_sel;
      out_data.slot_index    <= cur_slot;
      out_data.drop_message  <= drop;
      out_data.wake_distance <= dist_wide[DIST_WIDTH-1:0];
    end
  end

  // Checks
  `TSS_ASSERT_NEXT(a_accept_starts_run, in_accept,
    (fsm == S_RUN) && (step_cnt == '0), "accepted transaction did not start the run")
  `TSS_ASSERT_IMPLY(a_no_overwrite, out_load, !out_valid || !out_stall,
    "result loaded over a stalled result")
  `TSS_ASSERT_NEXT(a_slot_holds, !out_load, $stable(cur_slot),
    "slot counter moved without a decision")
  `TSS_ASSERT_NEXT(a_load_gives_valid, out_load, out_valid && (fsm == S_IDLE),
    "decision load did not present a result")

endmodule

// ----- rtl/core/tss_rem_serial.sv -----
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Restoring remainder, one dividend bit per step, MSB first.
// ----------------------------------------------------------------------------
module tss_rem_serial #(
  parameter int DIVIDEND_WIDTH = 16,
  parameter int DIVISOR_WIDTH  = 8
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [DIVIDEND_WIDTH-1:0] dividend,
  input  logic [DIVISOR_WIDTH-1:0]  divisor,
  output logic [DIVISOR_WIDTH-1:0]  remainder
);

  logic [DIVIDEND_WIDTH-1:0] shift;
  logic [DIVISOR_WIDTH-1:0]  rem;
  logic [DIVISOR_WIDTH:0]    trial;
  logic [DIVISOR_WIDTH:0]    rem_next;

  // Bring in the next bit; subtract when the partial remainder reaches the divisor
  always_comb begin
    trial = {rem, shift[DIVIDEND_WIDTH-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = trial - {1'b0, divisor};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift <= dividend;
      rem   <= '0;
    end else if (step) begin
      shift <= {shift[DIVIDEND_WIDTH-2:0], 1'b0};
      rem   <= rem_next[DIVISOR_WIDTH-1:0];
    end
  end

  assign remainder = rem;

endmodule

// ----- dv/tdma_slot_state_scheduler_checker.sv -----
// ----------------------------------------------------------------------------
// TDMA slot scheduler checker
// Watches the config, input and output channels, predicts every slot
// decision from a shadow of the registers and the frame counter, and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module tdma_slot_decision_checker
  import tss_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  in_item_t                  in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  out_item_t                 out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
  output int                        fail_count,
  output int                        outstanding
);

  logic [SLOT_WIDTH-1:0] reg_slot_count;
  logic [ADDR_WIDTH-1:0] reg_node_address;
  logic                  reg_sink_mode;
  logic [SLOT_WIDTH-1:0] frame_slot;
  out_item_t             expected_decisions[$];
  int                    errors = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] slot decision mismatch: %s", $time, msg);
    errors++;
  endtask

  // Decide the radio state, drop flag and wake distance for the current slot, then advance the frame counter.
  function automatic out_item_t predict_decision(in_item_t item);
    int unsigned slots;
    int unsigned cur;
    int unsigned own;
    int unsigned dslot;
    int unsigned wake;
    logic        unicast;
    logic        drop;
    logic        pending;
    out_item_t   res;
    slots   = (reg_slot_count == 0) ? 1 : reg_slot_count;
    cur     = frame_slot;
    own     = reg_node_address % slots;
    dslot   = item.dest_address % slots;
    unicast = item.has_message && !item.is_broadcast;
    drop    = unicast && (dslot == own);
    pending = item.has_message && !drop;
    res     = '0;

    if (cur == own) begin
      res.slot_state = ST_RECEIVE;
    end else if (pending && item.is_broadcast && cur == slots) begin
      res.slot_state = ST_SEND_RECEIVE;
    end else if (pending && !item.is_broadcast &&
                 (dslot == cur ||
                  (reg_sink_mode && item.dest_address == 0 && cur != slots))) begin
      res.slot_state = ST_SEND;
    end else if (cur == slots) begin
      res.slot_state = ST_RECEIVE;
    end else if (reg_sink_mode && reg_node_address == 0) begin
      res.slot_state = ST_RECEIVE;
    end else begin
      res.slot_state = ST_SLEEP;
    end

    wake = 0;
    if (unicast && !drop) begin
      // a counter past the common slot behaves as if slot 0 came next
      if (cur > slots) begin
        wake = dslot + 1;
      end else if (dslot > cur) begin
        wake = dslot - cur;
      end else begin
        wake = dslot + slots + 1 - cur;
      end
    end

    res.slot_index    = frame_slot;
    res.drop_message  = drop;
    res.wake_distance = wake[DIST_WIDTH-1:0];

    frame_slot = (cur >= slots) ? '0 : SLOT_WIDTH'(cur + 1);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      reg_slot_count   = SLOT_COUNT_RESET;
      reg_node_address = '0;
      reg_sink_mode    = 1'b0;
      frame_slot       = '0;
      expected_decisions.delete();
      errors           = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_decisions.size() == 0) begin
          report_mismatch("result transaction with no decision pending");
        end else begin
          want = expected_decisions.pop_front();
          if (out_data.slot_state !== want.slot_state) begin
            report_mismatch($sformatf("slot %0d: slot_state got %0d, want %0d",
                                      want.slot_index, out_data.slot_state,
                                      want.slot_state));
          end
          if (out_data.slot_index !== want.slot_index) begin
            report_mismatch($sformatf("slot_index got %0d, want %0d",
                                      out_data.slot_index, want.slot_index));
          end
          if (out_data.drop_message !== want.drop_message) begin
            report_mismatch($sformatf("slot %0d: drop_message got %0b, want %0b",
                                      want.slot_index, out_data.drop_message,
                                      want.drop_message));
          end
          if (out_data.wake_distance !== want.wake_distance) begin
            report_mismatch($sformatf("slot %0d: wake_distance got %0d, want %0d",
                                      want.slot_index, out_data.wake_distance,
                                      want.wake_distance));
          end
        end
      end

      if (in_valid && !in_stall) begin
        expected_decisions.push_back(predict_decision(in_data));
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SLOT_COUNT:   reg_slot_count   = cfg_data[SLOT_WIDTH-1:0];
          CFG_NODE_ADDRESS: reg_node_address = cfg_data[ADDR_WIDTH-1:0];
          CFG_SINK_MODE:    reg_sink_mode    = cfg_data[0];
          default: ;
        endcase
      end
    end
    fail_count  <= errors;
    outstanding <= expected_decisions.size();
  end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// TDMA slot scheduler testbench
// Drives slot boundaries and register writes into the scheduler with random
// gaps and stalls on both channels; a checker beside the block predicts and
// compares every decision, and this top gives the verdict from its count.
// ----------------------------------------------------------------------------
module testbench;
  import tss_pkg::*;

  // Run limits. ~550 transactions with heavy stalls stay far below the limit.
  localparam int LIMIT_CYCLES  = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 2 * (ADDR_WIDTH + 2);
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 44;

  // Who idles: receiver heavy, sender heavy, or nobody.
  typedef enum logic [1:0] {
    IDLE_RX_HEAVY,
    IDLE_TX_HEAVY,
    IDLE_OFF
  } idle_mode_t;

  logic                      clk        = 1'b0;
  logic                      rst        = 1'b1;
  logic                      in_valid   = 1'b0;
  in_item_t                  in_data    = '0;
  logic                      in_stall;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index  = CFG_SLOT_COUNT;
  logic [CFG_DATA_WIDTH-1:0] cfg_data   = '0;

  idle_mode_t                idle_mode  = IDLE_RX_HEAVY;
  logic                      hold_req   = 1'b0;
  logic                      hold_taken = 1'b0;
  int                        hold_left  = 0;
  int                        cycle_count = 0;
  int                        fail_count;
  int                        outstanding;

  // What was last written, kept only to aim destinations at interesting slots.
  int unsigned               phase_slots = 16;
  logic [ADDR_WIDTH-1:0]     phase_node  = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tdma_slot_state_scheduler u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tdma_slot_decision_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  function automatic int tx_idle_pct(idle_mode_t mode);
    case (mode)
      IDLE_RX_HEAVY: return 26;
      IDLE_TX_HEAVY: return 61;
      default:       return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct(idle_mode_t mode);
    case (mode)
      IDLE_RX_HEAVY: return 61;
      IDLE_TX_HEAVY: return 26;
      default:       return 0;
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request so the block
  // fills up and pushes back on its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct(idle_mode));
    end
  end

  // Offer one slot boundary; hold it until the block takes it.
  task automatic send_slot(in_item_t item);
    while ($urandom_range(0, 99) < tx_idle_pct(idle_mode)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Pause the sender until every predicted decision has come back.
  task automatic drain_decisions();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Leave cfg_valid high; the caller drops it after the last write.
  task automatic put_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all three registers; junk in the unused data bits must be ignored.
  task automatic configure(logic [SLOT_WIDTH-1:0] slots, logic [ADDR_WIDTH-1:0] node,
                           logic sink);
    put_reg(CFG_SLOT_COUNT, CFG_DATA_WIDTH'({$urandom(), slots}));
    put_reg(CFG_NODE_ADDRESS, node);
    put_reg(CFG_SINK_MODE, CFG_DATA_WIDTH'({$urandom(), sink}));
    cfg_valid   <= 1'b0;
    phase_slots = (slots == 0) ? 1 : slots;
    phase_node  = node;
  endtask

  // Mostly unicast, with a fair share aimed at the own slot (dropped), at
  // node 0 and at nearby slots; the rest spread over the whole address range.
  function automatic in_item_t random_slot_item();
    in_item_t    item;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    item.has_message  = (kind >= 12);
    item.is_broadcast = (kind < 12) ? 1'($urandom_range(0, 1)) : (kind < 32);
    case ($urandom_range(0, 9))
      0:       item.dest_address = '0;
      1:       item.dest_address = '1;
      2, 3:    item.dest_address = ADDR_WIDTH'(phase_node + phase_slots * $urandom_range(0, 3));
      4, 5:    item.dest_address = ADDR_WIDTH'($urandom_range(0, 2 * phase_slots + 1));
      default: item.dest_address = ADDR_WIDTH'($urandom());
    endcase
    return item;
  endfunction

  // Stop a hung run.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tdma_slot_state_scheduler test failed");
    $finish;
  end

  initial begin
    logic [SLOT_WIDTH-1:0] slots;
    logic [ADDR_WIDTH-1:0] node;
    logic                  sink;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Four slots, top address: own slot 3, common slot 4. Walk the frame twice:
    // no message, send to an awake slot, a dropped unicast, a broadcast in the
    // own slot and in the common slot, and unicasts that only wait.
    configure(8'd4, 16'hFFFF, 1'b0);
    send_slot(in_item_t'{1'b0, 1'b0, 16'h0000});
    send_slot(in_item_t'{1'b1, 1'b0, 16'h0001});
    send_slot(in_item_t'{1'b1, 1'b0, 16'hFFFF});
    send_slot(in_item_t'{1'b1, 1'b1, 16'h0000});
    send_slot(in_item_t'{1'b1, 1'b1, 16'hFFFF});
    send_slot(in_item_t'{1'b1, 1'b0, 16'h0002});
    send_slot(in_item_t'{1'b0, 1'b1, 16'hFFFF});
    send_slot(in_item_t'{1'b1, 1'b0, 16'h8000});
    send_slot(in_item_t'{1'b1, 1'b0, 16'h0000});
    send_slot(in_item_t'{1'b1, 1'b0, 16'h0001});

    // Widest frame with the sink bit set: send to node 0 in any slot, drop
    // destinations that alias the own slot, wait on a far one.
    drain_decisions();
    configure(8'd255, 16'd7, 1'b1);
    send_slot(in_item_t'{1'b1, 1'b0, 16'd0});
    send_slot(in_item_t'{1'b1, 1'b0, 16'd7});
    send_slot(in_item_t'{1'b1, 1'b0, 16'd262});
    send_slot(in_item_t'{1'b1, 1'b0, 16'd300});
    send_slot(in_item_t'{1'b1, 1'b1, 16'd0});

    // Shrink the frame under a counter already past the new common slot.
    drain_decisions();
    configure(8'd2, 16'd1, 1'b0);
    send_slot(in_item_t'{1'b1, 1'b0, 16'd4});
    send_slot(in_item_t'{1'b1, 1'b1, 16'hFFFF});

    // Zero slot count acts as one slot: every unicast drops.
    drain_decisions();
    configure(8'd0, 16'd0, 1'b1);
    send_slot(in_item_t'{1'b1, 1'b1, 16'd0});
    send_slot(in_item_t'{1'b1, 1'b0, 16'hFFFF});
    send_slot(in_item_t'{1'b0, 1'b0, 16'd0});

    // Random phases. Frame sizes alternate wide and narrow so the counter
    // often lands past a freshly lowered common slot.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_decisions();
      idle_mode <= (p < 4) ? IDLE_RX_HEAVY : (p < 8) ? IDLE_TX_HEAVY : IDLE_OFF;
      case (p)
        0, 5:    slots = 8'd255;
        1:       slots = 8'd3;
        2:       slots = 8'd0;
        3:       slots = 8'd1;
        6:       slots = 8'd2;
        default: slots = SLOT_WIDTH'($urandom_range(3, 40));
      endcase
      case ($urandom_range(0, 3))
        0:       node = '0;
        1:       node = '1;
        default: node = ADDR_WIDTH'($urandom());
      endcase
      if (p == 4 || p == 9) begin
        node = '0;
      end
      sink = (p % 3 == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      configure(slots, node, sink);
      // hold off the receiver while the sender keeps pushing at full rate
      if (p == 9) begin
        hold_req <= 1'b1;
      end
      repeat (PHASE_ITEMS) send_slot(random_slot_item());
    end

    drain_decisions();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tdma_slot_state_scheduler test passed");
    end else begin
      $display("tdma_slot_state_scheduler test failed");
    end
    $finish;
  end

endmodule
